// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms used by the serializer top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is high.
`define OSW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define OSW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/osw_pkg.sv =====
// ----------------------------------------------------------------------------
// osw_pkg
// Types, codes and the control store of the I2C write serializer.
// ----------------------------------------------------------------------------
package osw_pkg;

   // item opcodes
   localparam logic [2:0] OP_BEGIN_CMD  = 3'd0;
   localparam logic [2:0] OP_BEGIN_DATA = 3'd1;
   localparam logic [2:0] OP_CMD_BYTE   = 3'd2;
   localparam logic [2:0] OP_DATA_BYTE  = 3'd3;
   localparam logic [2:0] OP_END        = 3'd4;

   // register indexes
   localparam logic CSR_ADDRESS_BYTE = 1'b0;
   localparam logic CSR_INVERT_DATA  = 1'b1;

   localparam logic [7:0] ADDR_RESET  = 8'h78;
   localparam logic [7:0] CTL_COMMAND = 8'h00;
   localparam logic [7:0] CTL_DATA    = 8'h40;

   // program entry points
   localparam int         PC_W       = 4;
   localparam logic [3:0] STEP_START = 4'd0;
   localparam logic [3:0] STEP_BIT   = 4'd4;
   localparam logic [3:0] STEP_STOP  = 4'd10;

   typedef enum logic {
      LINE_SCL,
      LINE_SDA
   } line_type;

   typedef enum logic [1:0] {
      LVL_ZERO,
      LVL_ONE,
      LVL_MSB
   } level_src_type;

   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_LOAD_ADDR,
      SEQ_BIT_LOOP,
      SEQ_BYTE_END,
      SEQ_FINISH
   } seq_op_type;

   typedef struct packed {
      line_type      line;
      level_src_type src;
      seq_op_type    seq;
   } ctrl_word_type;

   // sequencer to datapath
   typedef struct packed {
      logic          fire;
      logic          done;
      ctrl_word_type word;
   } step_type;

   // datapath to sequencer
   typedef struct packed {
      logic bit_last;
      logic more;
   } status_type;

   // Control store: one line write per step.
   function automatic ctrl_word_type ctrl_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      case (pc)
         4'd0:    w = '{LINE_SCL, LVL_ONE,  SEQ_NEXT};      // start
         4'd1:    w = '{LINE_SDA, LVL_ONE,  SEQ_NEXT};
         4'd2:    w = '{LINE_SDA, LVL_ZERO, SEQ_NEXT};
         4'd3:    w = '{LINE_SCL, LVL_ZERO, SEQ_LOAD_ADDR};
         4'd4:    w = '{LINE_SDA, LVL_MSB,  SEQ_NEXT};      // data bit
         4'd5:    w = '{LINE_SCL, LVL_ONE,  SEQ_NEXT};
         4'd6:    w = '{LINE_SCL, LVL_ZERO, SEQ_BIT_LOOP};
         4'd7:    w = '{LINE_SDA, LVL_ONE,  SEQ_NEXT};      // ACK slot
         4'd8:    w = '{LINE_SCL, LVL_ONE,  SEQ_NEXT};
         4'd9:    w = '{LINE_SCL, LVL_ZERO, SEQ_BYTE_END};
         4'd10:   w = '{LINE_SCL, LVL_ZERO, SEQ_NEXT};      // stop
         4'd11:   w = '{LINE_SDA, LVL_ZERO, SEQ_NEXT};
         4'd12:   w = '{LINE_SCL, LVL_ONE,  SEQ_NEXT};
         4'd13:   w = '{LINE_SDA, LVL_ONE,  SEQ_FINISH};
         default: w = '{LINE_SDA, LVL_ONE,  SEQ_FINISH};
      endcase
      return w;
   endfunction

endpackage

// ===== sv/osw_sequencer.sv =====
// ----------------------------------------------------------------------------
// osw_sequencer
// Step counter, control store lookup and branch logic.
// ----------------------------------------------------------------------------
module osw_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_op,
   output logic                 req_stall,
   input  logic                 slot_free,
   input  osw_pkg::status_type  status,
   output osw_pkg::step_type    step
);

   logic                       busy_ff, busy_in;
   logic [osw_pkg::PC_W-1:0]   pc_ff, pc_in;
   osw_pkg::ctrl_word_type     word;
   logic                       fire;
   logic                       done;
   logic                       accept;

   assign word = osw_pkg::ctrl_rom(pc_ff);
   assign fire = busy_ff & slot_free;

   always_comb begin
      case (word.seq)
         osw_pkg::SEQ_FINISH:   done = 1'b1;
         osw_pkg::SEQ_BYTE_END: done = ~status.more;
         default:               done = 1'b0;
      endcase
   end

   // take a new item on the edge that issues the last step of the old one
   assign req_stall = busy_ff & ~(fire & done);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (fire) begin
         if (done) begin
            busy_in = 1'b0;
         end else begin
            case (word.seq)
               osw_pkg::SEQ_BIT_LOOP:
                  pc_in = status.bit_last ? pc_ff + 1'b1 : osw_pkg::STEP_BIT;
               osw_pkg::SEQ_BYTE_END:
                  pc_in = osw_pkg::STEP_BIT;
               default:
                  pc_in = pc_ff + 1'b1;
            endcase
         end
      end
      if (accept) begin
         case (req_op)
            osw_pkg::OP_BEGIN_CMD, osw_pkg::OP_BEGIN_DATA: begin
               busy_in = 1'b1;
               pc_in   = osw_pkg::STEP_START;
            end
            osw_pkg::OP_CMD_BYTE, osw_pkg::OP_DATA_BYTE: begin
               busy_in = 1'b1;
               pc_in   = osw_pkg::STEP_BIT;
            end
            osw_pkg::OP_END: begin
               busy_in = 1'b1;
               pc_in   = osw_pkg::STEP_STOP;
            end
            default: busy_in = 1'b0;   // drop undefined ops
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= osw_pkg::STEP_START;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign step.fire = fire;
   assign step.done = done;
   assign step.word = word;

endmodule

// ===== sv/osw_datapath.sv =====
// ----------------------------------------------------------------------------
// osw_datapath
// Byte shifter, bit counter, line levels and the result register.
// ----------------------------------------------------------------------------
module osw_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [2:0]           req_op,
   input  logic [7:0]           req_value,
   input  logic [7:0]           address_byte,
   input  logic                 invert_data,
   input  osw_pkg::step_type    step,
   output osw_pkg::status_type  status,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic                 rsp_scl,
   output logic                 rsp_sda,
   output logic                 rsp_last
);

   logic [7:0] shift_ff, shift_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       more_ff, more_in;
   logic [7:0] ctl_ff, ctl_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       valid_ff, valid_in;
   logic       last_ff, last_in;
   logic       level;

   always_comb begin
      case (step.word.src)
         osw_pkg::LVL_ZERO: level = 1'b0;
         osw_pkg::LVL_ONE:  level = 1'b1;
         osw_pkg::LVL_MSB:  level = shift_ff[7];
         default:           level = 1'b1;
      endcase
   end

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      more_in  = more_ff;
      ctl_in   = ctl_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      last_in  = last_ff;
      valid_in = valid_ff & rsp_stall;
      if (step.fire) begin
         valid_in = 1'b1;
         last_in  = step.done;
         if (step.word.line == osw_pkg::LINE_SCL) begin
            scl_in = level;
         end else begin
            sda_in = level;
         end
         case (step.word.seq)
            osw_pkg::SEQ_LOAD_ADDR: begin
               shift_in = address_byte;
               cnt_in   = '0;
            end
            osw_pkg::SEQ_BIT_LOOP: begin
               shift_in = {shift_ff[6:0], 1'b0};
               cnt_in   = cnt_ff + 1'b1;
            end
            osw_pkg::SEQ_BYTE_END: begin
               if (more_ff) begin
                  shift_in = ctl_ff;
                  cnt_in   = '0;
                  more_in  = 1'b0;
               end
            end
            default: ;
         endcase
      end
      // a new item wins over the finishing step of the old one
      if (accept) begin
         cnt_in  = '0;
         more_in = 1'b0;
         case (req_op)
            osw_pkg::OP_BEGIN_CMD: begin
               ctl_in  = osw_pkg::CTL_COMMAND;
               more_in = 1'b1;
            end
            osw_pkg::OP_BEGIN_DATA: begin
               ctl_in  = osw_pkg::CTL_DATA;
               more_in = 1'b1;
            end
            osw_pkg::OP_CMD_BYTE:  shift_in = req_value;
            osw_pkg::OP_DATA_BYTE: shift_in = invert_data ? ~req_value : req_value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         valid_ff <= 1'b0;
         more_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         valid_ff <= valid_in;
         more_ff  <= more_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      ctl_ff   <= ctl_in;
      last_ff  <= last_in;
   end

   assign status.bit_last = (cnt_ff == 3'd7);
   assign status.more     = more_ff;

   // line levels only move on a fired step, so they double as the result beat
   assign rsp_valid = valid_ff;
   assign rsp_scl   = scl_ff;
   assign rsp_sda   = sda_ff;
   assign rsp_last  = last_ff;

endmodule

// ===== sv/oled_i2c_write_serializer.sv =====
// ----------------------------------------------------------------------------
// oled_i2c_write_serializer
// Write-only I2C master: turns display transfer items into SCL/SDA writes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per beat: req_op (begin command, begin data,
//   command byte, data byte, end) and req_value (the byte for byte ops).
//   rsp_* returns one beat per line write: rsp_scl and rsp_sda give the
//   levels after the write, rsp_last marks the final write of the item.
//   csr_* writes address_byte (index 0) and invert_data (index 1) while idle.
//   A microcoded sequencer steps through a 14-word control store, issuing
//   one line write per cycle while the receiver does not stall; the output
//   register is the only pacing stage. The next item is taken on the edge
//   that issues the last write of the current one. After acceptance, each
//   fired step of the item lands in the output register. Undefined ops are
//   taken and dropped.
//   Reset: both lines idle high, address_byte 0x78, invert_data 0.
//   Receiver stall: the pending beat holds and the sequencer freezes on the
//   current step; req_stall stays high until the item finishes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oled_i2c_write_serializer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl,
   output logic       rsp_sda,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic [7:0]          address_byte_ff;
   logic                invert_data_ff;
   logic                accept;
   logic                slot_free;
   osw_pkg::step_type   step;
   osw_pkg::status_type status;

   // configuration registers; the user must write them only between items, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         address_byte_ff <= osw_pkg::ADDR_RESET;
         invert_data_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            osw_pkg::CSR_ADDRESS_BYTE: address_byte_ff <= csr_wdata;
            osw_pkg::CSR_INVERT_DATA:  invert_data_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // advance only when the result register is empty or draining
   assign slot_free = ~rsp_valid | ~rsp_stall;
   assign accept    = req_valid & ~req_stall;

   osw_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .slot_free (slot_free),
      .status    (status),
      .step      (step)
   );

   osw_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_op       (req_op),
      .req_value    (req_value),
      .address_byte (address_byte_ff),
      .invert_data  (invert_data_ff),
      .step         (step),
      .status       (status),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_scl      (rsp_scl),
      .rsp_sda      (rsp_sda),
      .rsp_last     (rsp_last)
   );

   // a fired step always lands in the result register
   `OSW_ASSERT(a_fire_gives_beat, step.fire |=> rsp_valid, "fired step lost")
   // the finishing step, and only it, carries the last flag
   `OSW_ASSERT(a_done_last, step.fire && step.done |=> rsp_last, "last flag missing")
   `OSW_ASSERT(a_not_done_last, step.fire && !step.done |=> !rsp_last, "early last flag")
   // no step may overwrite a beat the receiver still holds off
   `OSW_ASSERT(a_no_overrun, rsp_valid && rsp_stall |-> !step.fire, "result overrun")

endmodule

// ===== tb/oled_i2c_write_serializer_test.sv =====
// ----------------------------------------------------------------------------
// oled_i2c_write_serializer_test
// Self-checking bench for the write-only I2C serializer.
// Drives transfer items (begin, byte, end and undefined ops) through the
// request channel and predicts every SCL/SDA line write from its own
// model of the bus sequencer. Each response beat is checked against the
// oldest predicted write. Both sides idle at random, and the receiver
// holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module oled_i2c_write_serializer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 10;
   // quiet cycles allowed: a long receiver hold plus random gaps fit well below
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 500;
   localparam int HOLD_AT_FIRST  = 600;
   localparam int HOLD_AT_SECOND = 3000;
   localparam int REPORT_MAX   = 10;
   localparam int RANDOM_ITEMS = 34;
   localparam int PHASES       = 6;

   // opcodes the block takes and drops
   localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
   localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] value;
   } xfer_item_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic last;
   } line_write_type;

   // --------------------------------------------------------------------
   // DUT signals: every input starts at a known level
   // --------------------------------------------------------------------
   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_op    = osw_pkg::OP_BEGIN_CMD;
   logic [7:0] req_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl;
   logic       rsp_sda;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = osw_pkg::CSR_ADDRESS_BYTE;
   logic [7:0] csr_wdata = 8'h00;

   // --------------------------------------------------------------------
   // Bench state
   // --------------------------------------------------------------------
   xfer_item_type  items_pending[$];
   line_write_type line_writes_due[$];

   // shadow of the block's registers and bus lines
   logic [7:0] address_cfg = osw_pkg::ADDR_RESET;
   logic       invert_cfg  = 1'b0;
   logic       scl_now     = 1'b1;
   logic       sda_now     = 1'b1;

   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   int send_gap     = 0;
   int stall_left   = 0;
   int hold_left    = 0;
   int hold_beats   = 0;
   bit hold_on      = 1'b0;
   int rsp_beats    = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   oled_i2c_write_serializer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_scl   (rsp_scl),
      .rsp_sda   (rsp_sda),
      .rsp_last  (rsp_last),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // --------------------------------------------------------------------
   // Line write predictor
   // --------------------------------------------------------------------
   // Record one write on each line; the beat carries both line levels.
   function automatic void drive_scl(input logic level);
      scl_now = level;
      line_writes_due.push_back('{scl: scl_now, sda: sda_now, last: 1'b0});
   endfunction

   function automatic void drive_sda(input logic level);
      sda_now = level;
      line_writes_due.push_back('{scl: scl_now, sda: sda_now, last: 1'b0});
   endfunction

   // Shift a byte MSB first: set SDA, pulse SCL. Then an SCL pulse for the ACK
   // slot with SDA released high; the ACK slot is never sampled.
   function automatic void shift_byte(input logic [7:0] b);
      for (int i = 7; i >= 0; i--) begin
         drive_sda(b[i]);
         drive_scl(1'b1);
         drive_scl(1'b0);
      end
      drive_sda(1'b1);
      drive_scl(1'b1);
      drive_scl(1'b0);
   endfunction

   // Append every line write that one accepted item causes, then flag the
   // final one. Undefined ops leave no writes and no state change.
   function automatic void predict_line_writes(input logic [2:0] op, input logic [7:0] value);
      int             prior_count;
      line_write_type tail;
      prior_count = line_writes_due.size();
      case (op)
         osw_pkg::OP_BEGIN_CMD, osw_pkg::OP_BEGIN_DATA: begin
            // start condition: drop SDA while SCL is high, then drop SCL
            drive_scl(1'b1);
            drive_sda(1'b1);
            drive_sda(1'b0);
            drive_scl(1'b0);
            shift_byte(address_cfg);
            shift_byte(op == osw_pkg::OP_BEGIN_CMD ? osw_pkg::CTL_COMMAND
                                                   : osw_pkg::CTL_DATA);
         end
         osw_pkg::OP_CMD_BYTE:  shift_byte(value);
         osw_pkg::OP_DATA_BYTE: shift_byte(invert_cfg ? ~value : value);
         osw_pkg::OP_END: begin
            // stop condition: raise SDA while SCL is high
            drive_scl(1'b0);
            drive_sda(1'b0);
            drive_scl(1'b1);
            drive_sda(1'b1);
         end
         default: ;
      endcase
      if (line_writes_due.size() > prior_count) begin
         tail = line_writes_due.pop_back();
         tail.last = 1'b1;
         line_writes_due.push_back(tail);
      end
   endfunction

   // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // --------------------------------------------------------------------
   // Request driver: offer pending items, predict on each accepted beat
   // --------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      xfer_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) predict_line_writes(req_op, req_value);
         // hold the payload while stalled; advance once the beat is taken
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (items_pending.size() > 0) begin
               nxt = items_pending.pop_front();
               req_op    <= nxt.op;
               req_value <= nxt.value;
               req_valid <= 1'b1;
               send_gap = send_idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // Receiver hold: back the block up twice in the run while the sender
   // keeps offering
   // --------------------------------------------------------------------
   always @(posedge clock) begin : receiver_hold
      if (reset) begin
         hold_beats = 0;
         hold_left  = 0;
         hold_on   <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            hold_beats++;
            if (hold_beats == HOLD_AT_FIRST || hold_beats == HOLD_AT_SECOND)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            hold_on <= 1'b1;
         end else begin
            hold_on <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------
   // Response monitor: check each beat, then choose the next stall level
   // --------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      line_write_type due;
      logic           stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_beats++;
            if (line_writes_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("line write %0d: unexpected beat scl=%b sda=%b last=%b",
                           rsp_beats, rsp_scl, rsp_sda, rsp_last);
            end else begin
               due = line_writes_due.pop_front();
               if (rsp_scl !== due.scl || rsp_sda !== due.sda || rsp_last !== due.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"line write %0d: expected scl=%b sda=%b last=%b, ",
                               "got scl=%b sda=%b last=%b"},
                              rsp_beats, due.scl, due.sda, due.last,
                              rsp_scl, rsp_sda, rsp_last);
               end
            end
         end
         if (hold_on) begin
            stall_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (recv_idle_on) begin
            stall_left = pick_gap();
            stall_next = (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // --------------------------------------------------------------------
   // Watchdog: end the run if no beat moves for too long
   // --------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------
   task automatic queue_item(input logic [2:0] op, input logic [7:0] value);
      items_pending.push_back('{op: op, value: value});
   endtask

   // Write both registers on back-to-back edges; only called while idle.
   task automatic set_config(input logic [7:0] addr, input logic inv);
      csr_wr_en <= 1'b1;
      csr_index <= osw_pkg::CSR_ADDRESS_BYTE;
      csr_wdata <= addr;
      @(posedge clock);
      csr_index <= osw_pkg::CSR_INVERT_DATA;
      csr_wdata <= {7'b0, inv};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      address_cfg = addr;
      invert_cfg  = inv;
   endtask

   // Wait until every item is taken and every write has come back, then
   // let the block idle before the next phase reconfigures it.
   task automatic wait_drained();
      do @(posedge clock);
      while (items_pending.size() != 0 || req_valid || line_writes_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed transfers with random content, some loose noise.
   task automatic queue_random_traffic(input int target);
      int         done_count;
      int         nbytes;
      bit         is_data;
      logic [2:0] op;
      done_count = 0;
      while (done_count < target) begin
         if ($urandom_range(0, 99) < 75) begin
            is_data = 1'($urandom_range(0, 1));
            nbytes  = $urandom_range(1, 5);
            queue_item(is_data ? osw_pkg::OP_BEGIN_DATA : osw_pkg::OP_BEGIN_CMD,
                       8'($urandom_range(0, 255)));
            for (int k = 0; k < nbytes; k++)
               queue_item(is_data ? osw_pkg::OP_DATA_BYTE : osw_pkg::OP_CMD_BYTE,
                          8'($urandom_range(0, 255)));
            queue_item(osw_pkg::OP_END, 8'($urandom_range(0, 255)));
            done_count += nbytes + 2;
         end else begin
            op = 3'($urandom_range(0, 7));
            queue_item(op, 8'($urandom_range(0, 255)));
            if (op <= osw_pkg::OP_END) done_count++;
         end
      end
   endtask

   initial begin : stimulus
      int ph_idx;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (ph_idx = 0; ph_idx < PHASES; ph_idx++) begin
         case (ph_idx)
            0:       set_config(osw_pkg::ADDR_RESET, 1'b0);
            1:       set_config(8'hFF, 1'b1);
            2:       set_config(8'h00, 1'b0);
            3:       set_config(8'($urandom_range(0, 255)), 1'b1);
            4:       set_config(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            default: set_config(8'($urandom_range(0, 255)), 1'b0);
         endcase
         // mix idle patterns so some phases run with no gaps at all
         send_idle_on = (ph_idx % 2 == 0);
         recv_idle_on = (ph_idx % 3 != 1);

         if (ph_idx == 0) begin
            // command transfer with extreme bytes
            queue_item(osw_pkg::OP_BEGIN_CMD, 8'h00);
            queue_item(osw_pkg::OP_CMD_BYTE, 8'h00);
            queue_item(osw_pkg::OP_CMD_BYTE, 8'hFF);
            queue_item(osw_pkg::OP_CMD_BYTE, 8'hA5);
            queue_item(osw_pkg::OP_END, 8'hFF);
            // data transfer, no inversion
            queue_item(osw_pkg::OP_BEGIN_DATA, 8'hFF);
            queue_item(osw_pkg::OP_DATA_BYTE, 8'h00);
            queue_item(osw_pkg::OP_DATA_BYTE, 8'hFF);
            queue_item(osw_pkg::OP_DATA_BYTE, 8'h5A);
            queue_item(osw_pkg::OP_END, 8'h00);
            // undefined ops are taken and dropped
            for (int k = int'(OP_UNDEF_FIRST); k <= int'(OP_UNDEF_LAST); k++)
               queue_item(k[2:0], 8'hFF);
            // bytes with no begin, then ends and begins out of sequence
            queue_item(osw_pkg::OP_CMD_BYTE, 8'h81);
            queue_item(osw_pkg::OP_DATA_BYTE, 8'h7E);
            queue_item(osw_pkg::OP_END, 8'h00);
            queue_item(osw_pkg::OP_END, 8'hFF);
            queue_item(osw_pkg::OP_BEGIN_DATA, 8'h00);
            queue_item(osw_pkg::OP_BEGIN_CMD, 8'hFF);
            queue_item(osw_pkg::OP_DATA_BYTE, 8'h3C);
            queue_item(osw_pkg::OP_END, 8'h00);
         end else begin
            if (ph_idx == 1) begin
               // inverted data at the extremes
               queue_item(osw_pkg::OP_BEGIN_DATA, 8'h00);
               queue_item(osw_pkg::OP_DATA_BYTE, 8'h00);
               queue_item(osw_pkg::OP_DATA_BYTE, 8'hFF);
               queue_item(osw_pkg::OP_END, 8'h00);
            end
            queue_random_traffic(RANDOM_ITEMS);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (line_writes_due.size() != 0) begin
         mismatch_count++;
         $display("%0d line writes never arrived", line_writes_due.size());
      end
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/osw_pkg.sv
sv/osw_sequencer.sv
sv/osw_datapath.sv
sv/oled_i2c_write_serializer.sv
tb/oled_i2c_write_serializer_test.sv
